### sv/life_board_generations_assert.svh
// Assertion macros for the life board generations checker.
// Included by the checker file only; no other dependencies.
`ifndef LIFE_BOARD_GENERATIONS_ASSERT_SVH
`define LIFE_BOARD_GENERATIONS_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LBG_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LBG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/lbg_pkg.sv
// Shared constants for the life board generations block.
// No dependencies; used by the top level, the row unit and the checker.
`default_nettype none

package lbg_pkg;

   localparam int BOARD_SIZE_DEFAULT = 8;
   localparam int MAX_OUT_ROWS       = 8;

   localparam int ROW_CELLS_W  = 8;
   localparam int ROW_NUM_W    = 3;
   localparam int GEN_W        = 8;
   localparam int REQ_TDATA_W  = 8;
   localparam int RSP_TDATA_W  = 16;
   localparam int RSP_PAD_W    = RSP_TDATA_W - ROW_NUM_W - ROW_CELLS_W;

   localparam logic [GEN_W-1:0] GEN_COUNT_RESET = 8'd10;

   // Neighbour count of one cell, 0 to 8.
   localparam int NBR_W = 4;
   localparam logic [NBR_W-1:0] SURVIVE_MIN = 4'd2;
   localparam logic [NBR_W-1:0] BIRTH_COUNT = 4'd3;

endpackage

`default_nettype wire

### sv/lbg_row_unit.sv
// Next-generation logic for one board row from the rows above and below.
// Depends on lbg_pkg for the neighbour count width and the B3/S23 thresholds.
`default_nettype none

module lbg_row_unit #(
   parameter int BOARD_SIZE = lbg_pkg::BOARD_SIZE_DEFAULT
) (
   input  wire logic [BOARD_SIZE-1:0] up_row,
   input  wire logic [BOARD_SIZE-1:0] mid_row,
   input  wire logic [BOARD_SIZE-1:0] dn_row,
   output logic      [BOARD_SIZE-1:0] next_row
);

   // A dead column on either side keeps the edges free of special cases.
   logic [BOARD_SIZE+1:0] up_pad;
   logic [BOARD_SIZE+1:0] mid_pad;
   logic [BOARD_SIZE+1:0] dn_pad;
   logic [lbg_pkg::NBR_W-1:0] nbr_cnt [BOARD_SIZE];

   assign up_pad  = {1'b0, up_row, 1'b0};
   assign mid_pad = {1'b0, mid_row, 1'b0};
   assign dn_pad  = {1'b0, dn_row, 1'b0};

   for (genvar c = 0; c < BOARD_SIZE; c++) begin : g_col
      assign nbr_cnt[c] = lbg_pkg::NBR_W'(up_pad[c])  + lbg_pkg::NBR_W'(up_pad[c+1])
                        + lbg_pkg::NBR_W'(up_pad[c+2]) + lbg_pkg::NBR_W'(mid_pad[c])
                        + lbg_pkg::NBR_W'(mid_pad[c+2]) + lbg_pkg::NBR_W'(dn_pad[c])
                        + lbg_pkg::NBR_W'(dn_pad[c+1]) + lbg_pkg::NBR_W'(dn_pad[c+2]);

      assign next_row[c] = (nbr_cnt[c] == lbg_pkg::BIRTH_COUNT)
                         || (mid_row[c] && (nbr_cnt[c] == lbg_pkg::SURVIVE_MIN));
   end

endmodule

`default_nettype wire

### sv/life_board_generations.sv
// Conway life (B3/S23) board engine, top level.
// Depends on lbg_pkg and lbg_row_unit.
//
// Usage:
//   Board rows arrive on the req_ stream, one row per word, top row first; bit i of
//   req_tdata is column i and req_tlast marks the final row. A row is taken only
//   while idle. Rows never loaded are dead. Extra rows without tlast wrap to the top.
//   After the final row the block applies csr_wdata generations (register reset 10),
//   then sends the board on the rsp_ stream, one word per row from row zero, with
//   rsp_tlast on the last one (at most eight rows are sent).
//   Each generation sweeps the row store through its single read port and one row
//   unit; each emitted row is read from the store, loaded into the output register
//   and held there until taken. A receiver stall simply holds the current word in
//   the output register; the block waits without losing anything.
//   req_tready is low from the final row until the last result word is taken.
//   Reset (synchronous) clears the row valid bits, so the store reads as all dead,
//   sets the load pointer to row zero and the generation count to ten. After output
//   the valid bits are cleared, ready for the next board.
`default_nettype none

module life_board_generations #(
   parameter int BOARD_SIZE = lbg_pkg::BOARD_SIZE_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // req_tdata: [7:0] row_cells
   input  wire logic [lbg_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                            req_tlast,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // rsp_tdata: [2:0] row_number, [10:3] row_state, [15:11] zero
   output logic      [lbg_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic                            csr_we,
   input  wire logic [lbg_pkg::GEN_W-1:0]       csr_wdata
);

   localparam int ROW_W    = $clog2(BOARD_SIZE);
   localparam int STEP_W   = $clog2(BOARD_SIZE + 2);
   localparam int OUT_ROWS = (BOARD_SIZE < lbg_pkg::MAX_OUT_ROWS) ?
                             BOARD_SIZE : lbg_pkg::MAX_OUT_ROWS;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_GEN       = 3'd1;
   localparam logic [2:0] ST_EMIT_RD   = 3'd2;
   localparam logic [2:0] ST_EMIT_LD   = 3'd3;
   localparam logic [2:0] ST_EMIT_HOLD = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [lbg_pkg::GEN_W-1:0]    gen_cfg_ff, gen_cfg_in;
   logic [lbg_pkg::GEN_W-1:0]    gen_ff, gen_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic [ROW_W-1:0]             load_ptr_ff, load_ptr_in;
   logic [lbg_pkg::ROW_NUM_W-1:0] emit_ff, emit_in;
   logic [BOARD_SIZE-1:0]        up_ff, up_in;
   logic [BOARD_SIZE-1:0]        mid_ff, mid_in;
   logic [BOARD_SIZE-1:0]        row_valid_ff, row_valid_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic [lbg_pkg::ROW_NUM_W-1:0] rsp_num_ff, rsp_num_in;
   logic [lbg_pkg::ROW_CELLS_W-1:0] rsp_row_ff, rsp_row_in;

   // Row store: one write port, one registered read port.
   logic [BOARD_SIZE-1:0] store_mem [BOARD_SIZE];
   logic [BOARD_SIZE-1:0] rd_data_ff;
   logic                  rd_vld_ff;
   logic [ROW_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [ROW_W-1:0]      wr_addr;
   logic [BOARD_SIZE-1:0] wr_data;

   logic [BOARD_SIZE-1:0] rd_row;
   logic [BOARD_SIZE-1:0] dn_row;
   logic [BOARD_SIZE-1:0] new_row;
   logic                  req_take;
   logic                  rsp_take;
   logic                  gen_writes;

   assign req_take   = req_tvalid && req_tready;
   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // A row never written since the last clear reads as dead.
   assign rd_row     = rd_vld_ff ? rd_data_ff : '0;
   assign dn_row     = (step_ff <= STEP_W'(BOARD_SIZE)) ? rd_row : '0;
   assign gen_writes = (state_ff == ST_GEN) && (step_ff >= STEP_W'(2));

   lbg_row_unit #(
      .BOARD_SIZE (BOARD_SIZE)
   ) u_row_unit (
      .up_row   (up_ff),
      .mid_row  (mid_ff),
      .dn_row   (dn_row),
      .next_row (new_row)
   );

   always_comb begin
      rd_addr = '0;
      case (state_ff)
         ST_GEN: begin
            if (step_ff < STEP_W'(BOARD_SIZE)) begin
               rd_addr = ROW_W'(step_ff);
            end
         end
         ST_EMIT_RD: begin
            rd_addr = ROW_W'(emit_ff);
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = load_ptr_ff;
      wr_data = BOARD_SIZE'(req_tdata);
      if (req_take) begin
         wr_en = 1'b1;
      end else if (gen_writes) begin
         // The window trails the read pointer by two rows, so the row written
         // back in place has already been consumed by its neighbours' update.
         wr_en   = 1'b1;
         wr_addr = ROW_W'(step_ff - STEP_W'(2));
         wr_data = new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
      rd_vld_ff  <= row_valid_ff[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      gen_cfg_in   = gen_cfg_ff;
      gen_in       = gen_ff;
      step_in      = step_ff;
      load_ptr_in  = load_ptr_ff;
      emit_in      = emit_ff;
      up_in        = up_ff;
      mid_in       = mid_ff;
      row_valid_in = row_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_row_in   = rsp_row_ff;

      if (csr_we) begin
         gen_cfg_in = csr_wdata;
      end
      if (wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (load_ptr_ff == ROW_W'(BOARD_SIZE - 1)) begin
                  load_ptr_in = '0;
               end else begin
                  load_ptr_in = load_ptr_ff + ROW_W'(1);
               end
               if (req_tlast) begin
                  load_ptr_in = '0;
                  gen_in      = '0;
                  step_in     = '0;
                  emit_in     = '0;
                  state_in    = (gen_cfg_ff == '0) ? ST_EMIT_RD : ST_GEN;
               end
            end
         end
         ST_GEN: begin
            if (step_ff == '0) begin
               up_in  = '0;
               mid_in = '0;
            end else begin
               up_in  = mid_ff;
               mid_in = dn_row;
            end
            if (step_ff == STEP_W'(BOARD_SIZE + 1)) begin
               step_in = '0;
               gen_in  = gen_ff + lbg_pkg::GEN_W'(1);
               if (gen_in == gen_cfg_ff) begin
                  state_in = ST_EMIT_RD;
               end
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_num_in   = emit_ff;
            rsp_row_in   = lbg_pkg::ROW_CELLS_W'(rd_row);
            rsp_last_in  = (emit_ff == lbg_pkg::ROW_NUM_W'(OUT_ROWS - 1));
            state_in     = ST_EMIT_HOLD;
         end
         ST_EMIT_HOLD: begin
            if (rsp_take) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  row_valid_in = '0;
                  state_in     = ST_IDLE;
               end else begin
                  emit_in  = emit_ff + lbg_pkg::ROW_NUM_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_cfg_ff   <= lbg_pkg::GEN_COUNT_RESET;
         gen_ff       <= '0;
         step_ff      <= '0;
         load_ptr_ff  <= '0;
         emit_ff      <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_cfg_ff   <= gen_cfg_in;
         gen_ff       <= gen_in;
         step_ff      <= step_in;
         load_ptr_ff  <= load_ptr_in;
         emit_ff      <= emit_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      up_ff       <= up_in;
      mid_ff      <= mid_in;
      rsp_last_ff <= rsp_last_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_row_ff  <= rsp_row_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{lbg_pkg::RSP_PAD_W{1'b0}}, rsp_row_ff, rsp_num_ff};

endmodule

`default_nettype wire

### sv/lbg_checker.sv
// Port-level assertions for life_board_generations, attached by bind.
// Depends on lbg_pkg and the macros in life_board_generations_assert.svh.
`default_nettype none
`include "life_board_generations_assert.svh"

module lbg_checker #(
   parameter int BOARD_SIZE = lbg_pkg::BOARD_SIZE_DEFAULT
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            req_tlast,
   input wire logic [lbg_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tlast,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready
);

   localparam int OUT_ROWS = (BOARD_SIZE < lbg_pkg::MAX_OUT_ROWS) ?
                             BOARD_SIZE : lbg_pkg::MAX_OUT_ROWS;

   // The block never takes a new row while a result word is on offer.
   `LBG_ASSERT_SAME(a_no_overlap, clock, reset, rsp_tvalid, !req_tready, "input ready while result pending")

   // Accepting the final row of a board makes the block busy.
   `LBG_ASSERT_NEXT(a_busy_after_last, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready, "ready after final row")

   // A stalled result word holds its contents.
   `LBG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result changed")

   // The flagged word is always the final emitted row.
   `LBG_ASSERT_SAME(a_last_row_num, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[2:0] == 3'(OUT_ROWS - 1), "last flag on wrong row")

endmodule

bind life_board_generations lbg_checker #(
   .BOARD_SIZE (BOARD_SIZE)
) u_lbg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire

### test/tb.sv
// Self-checking bench for life_board_generations: directed boards, then random ones.
// Needs lbg_pkg and the block's RTL; results are checked against a local life predictor.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS          = lbg_pkg::BOARD_SIZE_DEFAULT;
   localparam int SETTLE_CYCLES = 16;
   localparam int LONG_HOLD     = 400;
   localparam int LEAD_WORDS    = 23;

   typedef struct {
      logic [lbg_pkg::ROW_NUM_W-1:0]   row_number;
      logic [lbg_pkg::ROW_CELLS_W-1:0] row_state;
      logic                            last_out;
   } row_word_type;

   // One directed word; on the final word of a board the result may be typed in.
   typedef struct {
      int                              gens;    // generation count written first, -1 keeps it
      logic [lbg_pkg::ROW_CELLS_W-1:0] cells;
      bit                              last;
      bit                              typed;
      logic [ROWS*ROWS-1:0]            board;   // row 0 in the low byte
   } lead_word_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic [lbg_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                            req_tlast = 1'b0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [lbg_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic                            csr_we = 1'b0;
   logic [lbg_pkg::GEN_W-1:0]       csr_wdata = '0;

   // Predictor state and the rows still owed by the block.
   logic [ROWS*ROWS-1:0]      board_now = '0;
   int                        load_ptr = 0;
   logic [lbg_pkg::GEN_W-1:0] gen_count = lbg_pkg::GEN_COUNT_RESET;
   row_word_type              pending_rows[$];
   row_word_type              want;
   int                        fault_count = 0;

   int sender_idle_pct = 0;
   int rsp_idle_pct    = 0;
   int rsp_hold_left   = 0;

   life_board_generations dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [ROWS*ROWS-1:0] life_step(input logic [ROWS*ROWS-1:0] cur);
      logic [ROWS*ROWS-1:0] nxt;
      int                   count;
      nxt = '0;
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < ROWS; c++) begin
            count = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < ROWS &&
                      c + dc >= 0 && c + dc < ROWS)
                     count += cur[(r + dr) * ROWS + c + dc];
               end
            end
            if (cur[r * ROWS + c])
               nxt[r * ROWS + c] = (count == lbg_pkg::SURVIVE_MIN ||
                                    count == lbg_pkg::BIRTH_COUNT);
            else
               nxt[r * ROWS + c] = (count == lbg_pkg::BIRTH_COUNT);
         end
      end
      return nxt;
   endfunction

   // Offers one row and, once it is taken, updates the predicted board.
   task automatic send_row(input logic [lbg_pkg::ROW_CELLS_W-1:0] cells, input bit last,
                           input bit typed, input logic [ROWS*ROWS-1:0] board);
      logic [ROWS*ROWS-1:0] settled;
      row_word_type         word_out;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = cells;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      board_now[load_ptr * ROWS +: ROWS] = cells;
      load_ptr = (load_ptr + 1) % ROWS;
      if (last) begin
         for (int g = 0; g < gen_count; g++)
            board_now = life_step(board_now);
         settled = typed ? board : board_now;
         for (int k = 0; k < ROWS; k++) begin
            word_out.row_number = lbg_pkg::ROW_NUM_W'(k);
            word_out.row_state  = settled[k * ROWS +: ROWS];
            word_out.last_out   = (k == ROWS - 1);
            pending_rows.push_back(word_out);
         end
         board_now = '0;
         load_ptr  = 0;
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_rows.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_generations(input logic [lbg_pkg::GEN_W-1:0] g);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = g;
      @(negedge clock);
      csr_we    = 1'b0;
      gen_count = g;
   endtask

   function automatic logic [lbg_pkg::ROW_CELLS_W-1:0] pick_cells();
      case ($urandom_range(5))
         0: return lbg_pkg::ROW_CELLS_W'($urandom & $urandom);
         4: return $urandom_range(1) ? '1 : '0;
         5: return lbg_pkg::ROW_CELLS_W'(1) << $urandom_range(lbg_pkg::ROW_CELLS_W - 1);
         default: return lbg_pkg::ROW_CELLS_W'($urandom);
      endcase
   endfunction

   // Receiver: random stalls, plus a long hold-off when one is requested.
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_tready = 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_tready = ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rows.size() == 0) begin
            $error("unexpected result word: row_number %0d row_state %h",
                   rsp_tdata[lbg_pkg::ROW_NUM_W-1:0],
                   rsp_tdata[lbg_pkg::ROW_NUM_W +: lbg_pkg::ROW_CELLS_W]);
            fault_count++;
         end else begin
            want = pending_rows.pop_front();
            if (rsp_tdata[lbg_pkg::ROW_NUM_W-1:0] !== want.row_number) begin
               $error("row_number: expected %0d, got %0d", want.row_number,
                      rsp_tdata[lbg_pkg::ROW_NUM_W-1:0]);
               fault_count++;
            end
            if (rsp_tdata[lbg_pkg::ROW_NUM_W +: lbg_pkg::ROW_CELLS_W] !== want.row_state) begin
               $error("row_state: expected %h, got %h", want.row_state,
                      rsp_tdata[lbg_pkg::ROW_NUM_W +: lbg_pkg::ROW_CELLS_W]);
               fault_count++;
            end
            if (rsp_tlast !== want.last_out) begin
               $error("last_out: expected %b, got %b", want.last_out, rsp_tlast);
               fault_count++;
            end
            if (rsp_tdata[lbg_pkg::RSP_TDATA_W-1 -: lbg_pkg::RSP_PAD_W] !== '0) begin
               $error("rsp_tdata padding: expected 0, got %h",
                      rsp_tdata[lbg_pkg::RSP_TDATA_W-1 -: lbg_pkg::RSP_PAD_W]);
               fault_count++;
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      lead_word_type lead[LEAD_WORDS] = '{
         // Reset count of ten: a still-life block survives unchanged.
         '{-1,  8'h18, 0, 0, 64'h0},
         '{-1,  8'h18, 0, 0, 64'h0},
         '{-1,  8'h00, 1, 1, 64'h0000_0000_0000_1818},
         // No generations: the board comes back as loaded, missing rows dead.
         '{0,   8'hFF, 0, 0, 64'h0},
         '{-1,  8'h81, 0, 0, 64'h0},
         '{-1,  8'h5A, 1, 1, 64'h0000_0000_005A_81FF},
         // Ten rows without a break: the load pointer wraps and overwrites the top.
         '{-1,  8'h01, 0, 0, 64'h0},
         '{-1,  8'h02, 0, 0, 64'h0},
         '{-1,  8'h04, 0, 0, 64'h0},
         '{-1,  8'h08, 0, 0, 64'h0},
         '{-1,  8'h10, 0, 0, 64'h0},
         '{-1,  8'h20, 0, 0, 64'h0},
         '{-1,  8'h40, 0, 0, 64'h0},
         '{-1,  8'h80, 0, 0, 64'h0},
         '{-1,  8'hAA, 0, 0, 64'h0},
         '{-1,  8'h55, 1, 1, 64'h8040_2010_0804_55AA},
         // One generation of a blinker turns it upright.
         '{1,   8'h00, 0, 0, 64'h0},
         '{-1,  8'h00, 0, 0, 64'h0},
         '{-1,  8'h00, 0, 0, 64'h0},
         '{-1,  8'h1C, 1, 1, 64'h0000_0008_0808_0000},
         // Maximum count: blocks in both top corners stay put, and a lone full top
         // row is left to the predictor.
         '{255, 8'hC3, 0, 0, 64'h0},
         '{-1,  8'hC3, 1, 1, 64'h0000_0000_0000_C3C3},
         '{-1,  8'hFF, 1, 0, 64'h0}
      };
      int gen_plan[9] = '{3, 255, 0, 1, 128, 2, 7, 255, 4};
      int budget;
      int sent;
      int rows;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (lead[i]) begin
         if (lead[i].gens >= 0)
            set_generations(lbg_pkg::GEN_W'(lead[i].gens));
         send_row(lead[i].cells, lead[i].last, lead[i].typed, lead[i].board);
      end

      for (int p = 0; p < 9; p++) begin
         set_generations(lbg_pkg::GEN_W'(gen_plan[p]));
         case (p / 3)
            0: begin
               sender_idle_pct = 25;
               rsp_idle_pct    = 86;
            end
            1: begin
               sender_idle_pct = 86;
               rsp_idle_pct    = 25;
            end
            default: begin
               sender_idle_pct = 0;
               rsp_idle_pct    = 0;
            end
         endcase
         // The receiver stops for a long stretch while rows keep coming, so the
         // block has to refuse the next board.
         if (p == 6) begin
            @(posedge clock);
            rsp_hold_left = LONG_HOLD;
         end
         budget = (gen_plan[p] > 40) ? 12 : 50;
         sent   = 0;
         while (sent < budget) begin
            rows = ($urandom_range(7) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 8);
            for (int r = 0; r < rows; r++)
               send_row(pick_cells(), r == rows - 1, 0, '0);
            sent += rows;
            if (p == 4 && sent == rows)
               drain();
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (fault_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
